FILE: hdl/hmse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hmse_pkg;

   localparam int COORD_BITS = 11;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_PLACE = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   localparam logic [1:0] REG_PALLET_WIDTH = 2'd0;
   localparam logic [1:0] REG_PALLET_DEPTH = 2'd1;
   localparam logic [1:0] REG_MIN_SUPPORT  = 2'd2;

   typedef struct packed {
      logic [1:0]  command;
      logic [6:0]  pos_x;
      logic [6:0]  pos_z;
      logic [11:0] base_height;
      logic [11:0] box_height;
      logic [7:0]  box_width;
      logic [7:0]  box_depth;
      logic [7:0]  zone_width;
      logic [7:0]  zone_depth;
   } req_type;

   typedef struct packed {
      logic        fits;
      logic [6:0]  found_x;
      logic [6:0]  found_z;
      logic [14:0] supported_cells;
      logic [14:0] footprint_cells;
      logic [12:0] stack_top;
   } rsp_type;

   typedef struct packed {
      logic [1:0] index;
      logic [9:0] data;
   } csr_type;

   typedef struct packed {
      logic [7:0] pallet_width;
      logic [7:0] pallet_depth;
      logic [9:0] min_support_permille;
   } cfg_type;

endpackage

`default_nettype wire

FILE: hdl/hmse_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface hmse_req_if import hmse_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hdl/hmse_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface hmse_rsp_if import hmse_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hdl/hmse_csr_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface hmse_csr_if import hmse_pkg::*; ();
   logic    valid;
   logic    ready;
   csr_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hdl/hmse_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module hmse_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 16384
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire  [$clog2(DEPTH)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]         wr_data,
   input  wire                      rd_en,
   input  wire  [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/hmse_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module hmse_engine import hmse_pkg::*; #(
   parameter int MAX_WIDTH   = 128,
   parameter int MAX_DEPTH   = 128,
   parameter int HEIGHT_BITS = 13,
   parameter int START_SPAN  = 3
) (
   input  wire      clock,
   input  wire      reset,
   input  cfg_type  cfg,
   input  wire      req_valid,
   input  req_type  req_data,
   output logic     req_ready,
   output logic     res_valid,
   output rsp_type  res_data,
   input  wire      res_ready
);

   localparam int DEPTH = MAX_WIDTH * MAX_DEPTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int OB    = (START_SPAN > 0) ? $clog2(START_SPAN + 1) : 1;
   localparam logic [HEIGHT_BITS-1:0] HMAX     = '1;
   localparam logic [AW-1:0]          LAST     = AW'(DEPTH - 1);
   localparam logic [COORD_BITS-1:0]  MAXW_C   = COORD_BITS'(MAX_WIDTH);
   localparam logic [COORD_BITS-1:0]  MAXD_C   = COORD_BITS'(MAX_DEPTH);
   localparam logic [7:0]             SPAN8    = 8'(START_SPAN);

   typedef enum logic [8:0] {
      ST_CLR    = 9'b000000001,
      ST_IDLE   = 9'b000000010,
      ST_PLACE  = 9'b000000100,
      ST_PDRAIN = 9'b000001000,
      ST_QPREP  = 9'b000010000,
      ST_QRUN   = 9'b000100000,
      ST_QDRAIN = 9'b001000000,
      ST_QEVAL  = 9'b010000000,
      ST_DONE   = 9'b100000000
   } state_type;

   function automatic logic [14:0] sat15(input logic [15:0] v);
      return (v > 16'h7FFF) ? 15'h7FFF : v[14:0];
   endfunction

   state_type              state_ff, state_in;
   logic [AW-1:0]          clr_addr_ff, clr_addr_in;
   logic                   clr_reply_ff, clr_reply_in;
   logic [HEIGHT_BITS-1:0] top_ff, top_in;
   logic [1:0]             cmd_ff, cmd_in;
   logic [COORD_BITS-1:0]  px0_ff, px0_in, pz0_ff, pz0_in;
   logic [11:0]            base_ff, base_in;
   logic [HEIGHT_BITS-1:0] nh_ff, nh_in;
   logic [15:0]            area_ff, area_in;
   logic [26:0]            prod_ff, prod_in;
   logic [7:0]             lenx_ff, lenx_in, lenz_ff, lenz_in;
   logic [7:0]             cx_ff, cx_in, cz_ff, cz_in;
   logic [OB-1:0]          ox_ff, ox_in, oz_ff, oz_in, dxm_ff, dxm_in, dzm_ff, dzm_in;
   logic [15:0]            cnt_ff, cnt_in;
   logic                   rd_valid_ff;
   logic [AW-1:0]          addr_q_ff;
   logic                   res_fits_ff, res_fits_in;
   logic [6:0]             res_x_ff, res_x_in, res_z_ff, res_z_in;
   logic [14:0]            res_sup_ff, res_sup_in;

   logic                   rd_en, wr_en;
   logic [AW-1:0]          rd_addr, wr_addr;
   logic [HEIGHT_BITS-1:0] wr_data, rd_data;

   logic [COORD_BITS-1:0]  w_eff, d_eff, x_cur, z_cur, sx, sz;
   logic [COORD_BITS-1:0]  in_px, in_pz, xe, ze;
   logic [15:0]            area_mul;
   logic [16:0]            nh_sum;
   logic [HEIGHT_BITS-1:0] nh_sat;
   logic [7:0]             diffx, diffz;
   logic                   in_bounds, win, accept;

   always_comb begin
      w_eff = ({3'b0, cfg.pallet_width} > MAXW_C) ? MAXW_C : {3'b0, cfg.pallet_width};
      d_eff = ({3'b0, cfg.pallet_depth} > MAXD_C) ? MAXD_C : {3'b0, cfg.pallet_depth};
      in_px = COORD_BITS'(req_data.pos_x);
      in_pz = COORD_BITS'(req_data.pos_z);
      area_mul = 16'(req_data.box_width * req_data.box_depth);
      nh_sum = 17'(req_data.base_height) + 17'(req_data.box_height);
      nh_sat = (nh_sum > 17'(HMAX)) ? HMAX : HEIGHT_BITS'(nh_sum);
      xe = ((in_px + COORD_BITS'(req_data.box_width)) < w_eff) ?
           (in_px + COORD_BITS'(req_data.box_width)) : w_eff;
      ze = ((in_pz + COORD_BITS'(req_data.box_depth)) < d_eff) ?
           (in_pz + COORD_BITS'(req_data.box_depth)) : d_eff;
      diffx = req_data.zone_width - req_data.box_width;
      diffz = req_data.zone_depth - req_data.box_depth;
      in_bounds = (in_px + COORD_BITS'(req_data.zone_width) <= w_eff)
               && (in_pz + COORD_BITS'(req_data.zone_depth) <= d_eff)
               && (req_data.zone_width >= req_data.box_width)
               && (req_data.zone_depth >= req_data.box_depth);
      sx = px0_ff + COORD_BITS'(ox_ff);
      sz = pz0_ff + COORD_BITS'(oz_ff);
      x_cur = sx + COORD_BITS'(cx_ff);
      z_cur = sz + COORD_BITS'(cz_ff);
      rd_addr = AW'(AW'(x_cur) * AW'(MAX_DEPTH)) + AW'(z_cur);
      win = (27'(cnt_ff + 16'd1) * 27'd1000) > prod_ff;
   end

   assign accept    = (state_ff == ST_IDLE) && req_valid;
   assign req_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign rd_en     = (state_ff == ST_PLACE) || (state_ff == ST_QRUN);

   // read-modify-write: the write comes in the cycle after its read, cells are distinct
   always_comb begin
      if (state_ff == ST_CLR) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = rd_valid_ff && (cmd_ff == CMD_PLACE) && (rd_data < nh_ff);
         wr_addr = addr_q_ff;
         wr_data = nh_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      clr_reply_in = clr_reply_ff;
      top_in       = top_ff;
      cmd_in       = cmd_ff;
      px0_in       = px0_ff;
      pz0_in       = pz0_ff;
      base_in      = base_ff;
      nh_in        = nh_ff;
      area_in      = area_ff;
      prod_in      = prod_ff;
      lenx_in      = lenx_ff;
      lenz_in      = lenz_ff;
      cx_in        = cx_ff;
      cz_in        = cz_ff;
      ox_in        = ox_ff;
      oz_in        = oz_ff;
      dxm_in       = dxm_ff;
      dzm_in       = dzm_ff;
      cnt_in       = cnt_ff;
      res_fits_in  = res_fits_ff;
      res_x_in     = res_x_ff;
      res_z_in     = res_z_ff;
      res_sup_in   = res_sup_ff;

      if (rd_valid_ff && (cmd_ff == CMD_QUERY)
          && (16'(rd_data) == 16'(base_ff))) begin
         cnt_in = cnt_ff + 16'd1;
      end

      case (state_ff)
         ST_CLR: begin
            if (clr_addr_ff == LAST) begin
               state_in     = clr_reply_ff ? ST_DONE : ST_IDLE;
               clr_reply_in = 1'b0;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd_in      = req_data.command;
               px0_in      = in_px;
               pz0_in      = in_pz;
               base_in     = req_data.base_height;
               area_in     = area_mul;
               cx_in       = '0;
               cz_in       = '0;
               ox_in       = '0;
               oz_in       = '0;
               cnt_in      = '0;
               res_fits_in = 1'b0;
               res_x_in    = '0;
               res_z_in    = '0;
               res_sup_in  = '0;
               state_in    = ST_DONE;
               case (req_data.command)
                  CMD_CLEAR: begin
                     clr_addr_in  = '0;
                     clr_reply_in = 1'b1;
                     top_in       = '0;
                     res_fits_in  = 1'b1;
                     state_in     = ST_CLR;
                  end
                  CMD_PLACE: begin
                     nh_in       = nh_sat;
                     top_in      = (nh_sat > top_ff) ? nh_sat : top_ff;
                     res_fits_in = 1'b1;
                     res_x_in    = req_data.pos_x;
                     res_z_in    = req_data.pos_z;
                     lenx_in     = (xe > in_px) ? 8'(xe - in_px) : 8'd0;
                     lenz_in     = (ze > in_pz) ? 8'(ze - in_pz) : 8'd0;
                     if ((xe > in_px) && (ze > in_pz)) begin
                        state_in = ST_PLACE;
                     end
                  end
                  CMD_QUERY: begin
                     lenx_in = req_data.box_width;
                     lenz_in = req_data.box_depth;
                     dxm_in  = (diffx > SPAN8) ? OB'(START_SPAN) : OB'(diffx);
                     dzm_in  = (diffz > SPAN8) ? OB'(START_SPAN) : OB'(diffz);
                     if (req_data.base_height == 12'd0) begin
                        res_fits_in = 1'b1;
                        res_x_in    = req_data.pos_x;
                        res_z_in    = req_data.pos_z;
                        res_sup_in  = sat15(area_mul);
                     end else if (in_bounds) begin
                        state_in = ST_QPREP;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_PLACE, ST_QRUN: begin
            if (cz_ff == lenz_ff - 8'd1) begin
               cz_in = '0;
               if (cx_ff == lenx_ff - 8'd1) begin
                  cx_in    = '0;
                  state_in = (state_ff == ST_PLACE) ? ST_PDRAIN : ST_QDRAIN;
               end else begin
                  cx_in = cx_ff + 8'd1;
               end
            end else begin
               cz_in = cz_ff + 8'd1;
            end
         end
         ST_PDRAIN: begin
            state_in = ST_DONE;
         end
         ST_QPREP: begin
            prod_in  = 27'(cfg.min_support_permille) * 27'(area_ff);
            state_in = ((lenx_ff == 8'd0) || (lenz_ff == 8'd0)) ? ST_QEVAL : ST_QRUN;
         end
         ST_QDRAIN: begin
            state_in = ST_QEVAL;
         end
         ST_QEVAL: begin
            cnt_in = '0;
            if (win) begin
               res_fits_in = 1'b1;
               res_x_in    = sx[6:0];
               res_z_in    = sz[6:0];
               res_sup_in  = sat15(cnt_ff);
               state_in    = ST_DONE;
            end else if (oz_ff < dzm_ff) begin
               oz_in    = oz_ff + 1'b1;
               state_in = ST_QRUN;
            end else if (ox_ff < dxm_ff) begin
               ox_in    = ox_ff + 1'b1;
               oz_in    = '0;
               state_in = ST_QRUN;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         clr_addr_ff  <= '0;
         clr_reply_ff <= 1'b0;
         top_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         cmd_ff       <= CMD_CLEAR;
         cnt_ff       <= '0;
         lenx_ff      <= '0;
         lenz_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         clr_reply_ff <= clr_reply_in;
         top_ff       <= top_in;
         rd_valid_ff  <= rd_en;
         cmd_ff       <= cmd_in;
         cnt_ff       <= cnt_in;
         lenx_ff      <= lenx_in;
         lenz_ff      <= lenz_in;
      end
   end

   always_ff @(posedge clock) begin
      px0_ff      <= px0_in;
      pz0_ff      <= pz0_in;
      base_ff     <= base_in;
      nh_ff       <= nh_in;
      area_ff     <= area_in;
      prod_ff     <= prod_in;
      cx_ff       <= cx_in;
      cz_ff       <= cz_in;
      ox_ff       <= ox_in;
      oz_ff       <= oz_in;
      dxm_ff      <= dxm_in;
      dzm_ff      <= dzm_in;
      addr_q_ff   <= rd_addr;
      res_fits_ff <= res_fits_in;
      res_x_ff    <= res_x_in;
      res_z_ff    <= res_z_in;
      res_sup_ff  <= res_sup_in;
   end

   hmse_ram #(
      .WIDTH (HEIGHT_BITS),
      .DEPTH (DEPTH)
   ) u_cells (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      res_data.fits            = res_fits_ff;
      res_data.found_x         = res_x_ff;
      res_data.found_z         = res_z_ff;
      res_data.supported_cells = res_sup_ff;
      res_data.footprint_cells = sat15(area_ff);
      res_data.stack_top       = 13'(top_ff);
   end

   a_query_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QRUN || state_ff == ST_QDRAIN || state_ff == ST_QEVAL) |-> !wr_en)
      else $error("cell write during query walk");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != ST_IDLE))
      else $error("transfer accepted without leaving idle");

   a_drain_to_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PDRAIN) |=> (state_ff == ST_DONE))
      else $error("place drain did not finish");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QEVAL) |-> (cnt_ff <= 16'(lenx_ff * lenz_ff)))
      else $error("support count exceeds footprint");

endmodule

`default_nettype wire

FILE: hdl/height_map_support_engine_core.sv
// channel   dir  transfer            payload
// req_chan  in   valid & ready       command, position, heights, box and zone sizes
// rsp_chan  out  valid & ready       fits, found position, cell counts, stack top
// csr_chan  in   valid (ready = 1)   register index, write data
//
// one item at a time; the cell memory (one read and one write port) sets the rate
// place: walks each clipped footprint cell once, then drains the last write
// query: a prep state, then per start offset tried (at most 16) a cell walk, drain, eval
// clear, and after reset: clearing pass over all MAX_WIDTH * MAX_DEPTH cells, no req transfer
// a finished result waits in the output register while the next item is taken
`timescale 1ns / 1ps
`default_nettype none

module height_map_support_engine_core import hmse_pkg::*; #(
   parameter int MAX_WIDTH   = 128,
   parameter int MAX_DEPTH   = 128,
   parameter int HEIGHT_BITS = 13,
   parameter int START_SPAN  = 3
) (
   input wire        clock,
   input wire        reset,
   hmse_req_if.sink  req_chan,
   hmse_rsp_if.source rsp_chan,
   hmse_csr_if.sink  csr_chan
);

   cfg_type  cfg_ff;
   logic     rsp_valid_ff;
   rsp_type  rsp_data_ff;
   logic     res_valid, res_ready;
   rsp_type  res_data;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pallet_width         <= 8'd120;
         cfg_ff.pallet_depth         <= 8'd80;
         cfg_ff.min_support_permille <= 10'd750;
      end else if (csr_chan.valid) begin
         case (csr_chan.payload.index)
            REG_PALLET_WIDTH: cfg_ff.pallet_width <= csr_chan.payload.data[7:0];
            REG_PALLET_DEPTH: cfg_ff.pallet_depth <= csr_chan.payload.data[7:0];
            REG_MIN_SUPPORT:  cfg_ff.min_support_permille <= csr_chan.payload.data;
            default: begin
            end
         endcase
      end
   end

   // output register
   assign res_ready = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   hmse_engine #(
      .MAX_WIDTH   (MAX_WIDTH),
      .MAX_DEPTH   (MAX_DEPTH),
      .HEIGHT_BITS (HEIGHT_BITS),
      .START_SPAN  (START_SPAN)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_chan.valid),
      .req_data  (req_chan.payload),
      .req_ready (req_chan.ready),
      .res_valid (res_valid),
      .res_data  (res_data),
      .res_ready (res_ready)
   );

endmodule

`default_nettype wire
